// File: sv/slcfr_pkg.sv
// Shared types and constants for the sync/length/checksum frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_INDEX_W = 1;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

	localparam logic [BYTE_W-1:0] SYNC_VALUE_RESET = 8'd0;
	localparam logic [BYTE_W-1:0] TIMEOUT_TICKS_RESET = 8'd3;
	localparam logic [BYTE_W-1:0] IDLE_MAX = 8'hFF;

	// Item kinds
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic              payload_valid;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_good;
		logic              frame_bad;
		logic              timeout_abort;
	} out_item_t;

endpackage

`default_nettype wire

// File: sv/slcfr_in_reg.sv
// Input register stage: holds one accepted item until the core consumes it.
`timescale 1ns / 1ps
`default_nettype none

module slcfr_in_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire slcfr_pkg::in_item_t in_item,
	input  wire logic               advance,
	output logic                    valid_s1,
	output slcfr_pkg::in_item_t     item_s1
);
	import slcfr_pkg::*;

	logic valid_s1_q;

	// The stage frees up in the same cycle its item moves on
	assign in_ready = !valid_s1_q || advance;
	assign valid_s1 = valid_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// File: sv/slcfr_core.sv
// Frame state, configuration registers and the combinational step logic.
`timescale 1ns / 1ps
`default_nettype none

module slcfr_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [slcfr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [slcfr_pkg::BYTE_W-1:0]           cfg_wdata,
	input  wire logic                                   step,
	input  wire slcfr_pkg::in_item_t                    item_s1,
	output slcfr_pkg::out_item_t                        result
);
	import slcfr_pkg::*;

	typedef struct packed {
		logic              in_frame;
		logic              have_length;
		logic [BYTE_W-1:0] bytes_left;
		logic [BYTE_W-1:0] running_sum;
		logic [BYTE_W-1:0] write_index;
		logic [BYTE_W-1:0] idle_count;
	} frame_state_t;

	frame_state_t      state_q, state_d;
	logic [BYTE_W-1:0] sync_value_q;
	logic [BYTE_W-1:0] timeout_ticks_q;
	logic [BYTE_W-1:0] sum_next;
	logic [BYTE_W-1:0] left_next;
	logic [BYTE_W-1:0] idle_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q    <= SYNC_VALUE_RESET;
			timeout_ticks_q <= TIMEOUT_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_VALUE:    sync_value_q <= cfg_wdata;
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		sum_next  = state_q.running_sum + item_s1.rx_byte;
		left_next = state_q.bytes_left - 8'd1;
		idle_next = (state_q.idle_count == IDLE_MAX) ? state_q.idle_count
			: state_q.idle_count + 8'd1;
		state_d = state_q;
		result  = '0;
		if (item_s1.action == ACT_BYTE) begin
			state_d.idle_count = '0;
			if (!state_q.in_frame) begin
				if (item_s1.rx_byte == sync_value_q) begin
					state_d.in_frame    = 1'b1;
					state_d.have_length = 1'b0;
				end
			end else if (!state_q.have_length) begin
				// Length byte seeds the sum and loads the count with L-1
				state_d.have_length = 1'b1;
				state_d.running_sum = item_s1.rx_byte;
				state_d.bytes_left  = item_s1.rx_byte - 8'd1;
				state_d.write_index = '0;
			end else begin
				state_d.running_sum = sum_next;
				state_d.bytes_left  = left_next;
				if (left_next == '0) begin
					// Checksum byte closes the frame
					state_d.in_frame    = 1'b0;
					state_d.have_length = 1'b0;
					result.frame_good   = (sum_next == '0);
					result.frame_bad    = (sum_next != '0);
				end else begin
					result.payload_valid = 1'b1;
					result.payload_index = state_q.write_index;
					result.payload_byte  = item_s1.rx_byte;
					state_d.write_index  = state_q.write_index + 8'd1;
				end
			end
		end else begin
			state_d.idle_count = idle_next;
			if (state_q.in_frame && (idle_next > timeout_ticks_q)) begin
				state_d.in_frame     = 1'b0;
				state_d.have_length  = 1'b0;
				result.timeout_abort = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/slcfr_out_reg.sv
// Result register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module slcfr_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire slcfr_pkg::out_item_t result,
	output logic                      can_load,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output slcfr_pkg::out_item_t      out_item
);
	import slcfr_pkg::*;

	logic      out_valid_q;
	out_item_t out_item_q;

	assign can_load  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= result;
		end
	end

endmodule

`default_nettype wire

// File: sv/sync_length_checksum_frame_receiver.sv
// Top level of the sync/length/checksum frame receiver.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid/in_ready    in_item (action, rx_byte)
//   out_*        output     out_valid/out_ready  out_item (payload and frame flags)
//   cfg_*        input      cfg_we               cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready stays high. An item is first held in
// the input register, where the step logic updates the frame state, then sits in
// the result register. Reset clears the frame state and loads sync_value 0,
// timeout_ticks 3. When out_ready is low the result holds, the input register
// holds behind it, and in_ready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_checksum_frame_receiver (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire slcfr_pkg::in_item_t               in_item,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output slcfr_pkg::out_item_t                   out_item,
	input  wire logic                              cfg_we,
	input  wire logic [slcfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [slcfr_pkg::BYTE_W-1:0]      cfg_wdata
);
	import slcfr_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t result;
	logic      can_load;
	logic      advance;

	assign advance = valid_s1 && can_load;

	slcfr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	slcfr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item_s1   (item_s1),
		.result    (result)
	);

	slcfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// File: sv/slcfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module slcfr_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire slcfr_pkg::out_item_t out_item
);
	import slcfr_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// At most one event per result
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({out_item.payload_valid, out_item.frame_good,
			out_item.frame_bad, out_item.timeout_abort}))
		else $error("more than one event in one result");

	// Payload fields read zero when no payload byte is reported
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.payload_valid |->
			out_item.payload_index == '0 && out_item.payload_byte == '0)
		else $error("payload fields set without payload_valid");

	// While the result register is empty, input is never refused
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while result register empty");

endmodule

bind sync_length_checksum_frame_receiver slcfr_checker u_slcfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

`default_nettype wire
